[design/hrm_pkg.sv]
// ----------------------------------------------------------------------------
// hrm_pkg
// Shared types and constants of the histogram running median filter.
// ----------------------------------------------------------------------------
package hrm_pkg;

  localparam int NBINS      = 256;
  localparam int BIN_AW     = 8;
  localparam int PIX_W      = 8;
  localparam int RADIUS_W   = 4;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_SW     = 14;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_WALK,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_e;

  typedef struct packed {
    logic              valid;
    logic              inc;
    logic [BIN_AW-1:0] addr;
  } bin_req_t;

endpackage

[design/hrm_in_if.sv]
// ----------------------------------------------------------------------------
// hrm_in_if
// Pixel input channel: valid/ready handshake with op and three channels.
// ----------------------------------------------------------------------------
interface hrm_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] chan0_in;
  logic [7:0] chan1_in;
  logic [7:0] chan2_in;

  modport source (output valid, op, chan0_in, chan1_in, chan2_in, input ready);
  modport sink (input valid, op, chan0_in, chan1_in, chan2_in, output ready);
endinterface

[design/hrm_out_if.sv]
// ----------------------------------------------------------------------------
// hrm_out_if
// Median result channel: valid/ready handshake with medians and flags.
// ----------------------------------------------------------------------------
interface hrm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0_out;
  logic [7:0] chan1_out;
  logic [7:0] chan2_out;
  logic       row_end;
  logic       frame_end;
  logic       size_error;

  modport source (output valid, chan0_out, chan1_out, chan2_out, row_end, frame_end,
                  size_error, input ready);
  modport sink (input valid, chan0_out, chan1_out, chan2_out, row_end, frame_end,
                size_error, output ready);
endinterface

[design/hrm_row_store.sv]
// ----------------------------------------------------------------------------
// hrm_row_store
// Single-port-write, single-port-read pixel row memory, registered read.
// ----------------------------------------------------------------------------
module hrm_row_store #(
  parameter int Depth = 18432,
  parameter int AddrW = 15
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [23:0]      wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [23:0]      rdata_o
);

  logic [23:0] mem [Depth];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/hrm_bin_hist.sv]
// ----------------------------------------------------------------------------
// hrm_bin_hist
// One channel's 256-bin histogram: increment, or read and clear, per beat.
// ----------------------------------------------------------------------------
module hrm_bin_hist #(
  parameter int CntW = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hrm_pkg::bin_req_t req_i,
  output logic              rsp_valid_o,
  output logic [CntW-1:0]   rsp_cnt_o
);

  logic [CntW-1:0] mem [hrm_pkg::NBINS];
  logic [CntW-1:0] rdata_q;
  logic            p_valid_q, p_inc_q;
  logic [hrm_pkg::BIN_AW-1:0] p_addr_q, last_addr_q;
  logic            last_valid_q;
  logic [CntW-1:0] last_data_q;
  logic [CntW-1:0] cur, wr_data;

  // The previous write is not yet visible in the registered read data.
  always_comb begin
    cur = (last_valid_q && (last_addr_q == p_addr_q)) ? last_data_q : rdata_q;
    wr_data = p_inc_q ? cur + 1'b1 : '0;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.addr];
    if (p_valid_q) begin
      mem[p_addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q    <= 1'b0;
      p_inc_q      <= 1'b0;
      p_addr_q     <= '0;
      last_valid_q <= 1'b0;
      last_addr_q  <= '0;
      last_data_q  <= '0;
    end else begin
      p_valid_q    <= req_i.valid;
      p_inc_q      <= req_i.inc;
      p_addr_q     <= req_i.addr;
      last_valid_q <= p_valid_q;
      last_addr_q  <= p_addr_q;
      last_data_q  <= wr_data;
    end
  end

  assign rsp_valid_o = p_valid_q && !p_inc_q;
  assign rsp_cnt_o   = cur;

endmodule

[design/histogram_running_median_filter_core.sv]
// ----------------------------------------------------------------------------
// histogram_running_median_filter_core
// Three-channel square-window median filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on in_i (op push) in raster order; medians leave on out_o.
// Output row i is produced one beat per pushed pixel while input row
// i+radius+1 arrives; flush beats then drain the remaining rows, and the
// beat with frame_end closes the frame. radius, frame_width and frame_height
// are for the user to write over the APB port only while the block is idle;
// the block itself does not enforce it. Any write restarts the frame. For
// each median the row store delivers one window pixel per cycle and the
// median search reads all 256 bins of the histogram memories, clearing them
// on the way. A push that yields no result leaves the block idle.
// After reset the block clears all 256 bins of its histograms before it
// takes a beat. A finished result waits in the output register while the
// next beat is accepted; a stalled receiver holds the block before it loads
// the following result.
// ----------------------------------------------------------------------------
module histogram_running_median_filter_core #(
  parameter int MAX_RADIUS = 8,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrm_in_if.sink      in_i,
  hrm_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [hrm_pkg::PADDR_W-1:0] paddr,
  input  logic [hrm_pkg::PDATA_W-1:0] pwdata,
  output logic [hrm_pkg::PDATA_W-1:0] prdata,
  output logic        pready
);

  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CAW   = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(2 * MAX_RADIUS + 2);
  localparam int Depth = (2 * MAX_RADIUS + 2) * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int JW    = $clog2(MAX_WIDTH + MAX_RADIUS) + 1;
  localparam int RCW   = $clog2(2 * MAX_RADIUS + 1);
  localparam int HW    = hrm_pkg::HEIGHT_W;
  localparam int SRW   = hrm_pkg::ROW_SW;

  // Configuration.
  logic [hrm_pkg::RADIUS_W-1:0] radius_q, radius_d;
  logic [hrm_pkg::WIDTH_W-1:0]  width_q, width_d;
  logic [HW-1:0]                height_q, height_d;
  logic                         cfg_wr;
  hrm_pkg::reg_e                cfg_idx;
  logic                         cfg_hit;

  logic [RW-1:0]  r_eff;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic           err;
  logic [SW-1:0]  m_last;
  logic [RCW-1:0] two_r;
  logic [CW-1:0]  target;
  logic [2*RW+1:0] win_n;

  // Frame position.
  logic [HW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CAW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [SW-1:0]  in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic           in_col_last, out_col_last;
  logic [HW-1:0]  in_row_nx, out_row_nx;
  logic [CAW-1:0] in_col_nx, out_col_nx;
  logic [SW-1:0]  in_slot_nx, out_slot_nx;

  // Window scan.
  hrm_pkg::state_e st_q, st_d;
  logic signed [SRW-1:0] ip_q, ip_d, hm1_s;
  logic [SW-1:0]  slot_q, slot_d, slot_up, slot_dn;
  logic [CAW-1:0] ocol_q, ocol_d;
  logic signed [JW-1:0] jp_q, jp_d, wm1_s, ac_s, jp_start;
  logic [CAW-1:0] ac;
  logic [RCW-1:0] rcnt_q, rcnt_d, ccnt_q, ccnt_d;
  logic [RW-1:0]  prep_q, prep_d;
  logic [hrm_pkg::BIN_AW:0] walk_q, walk_d;
  logic           st_vld_q, st_vld_d;

  // Median search.
  logic [CW-1:0]  below_q [3];
  logic [CW-1:0]  below_d [3];
  logic           found_q [3];
  logic           found_d [3];
  logic [7:0]     med_q [3];
  logic [7:0]     med_d [3];
  logic [CW:0]    sum [3];

  // Pending result and output register.
  logic res_row_end_q, res_row_end_d, res_fe_q, res_fe_d, res_err_q, res_err_d;
  logic out_valid_q, out_valid_d, out_load;
  logic [7:0] out_ch_q [3];
  logic [7:0] out_ch_d [3];
  logic out_row_end_q, out_row_end_d, out_fe_q, out_fe_d, out_err_q, out_err_d;

  // Memories.
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [23:0]   st_rdata;
  hrm_pkg::bin_req_t bin_req [3];
  logic          bin_rsp_valid [3];
  logic [CW-1:0] bin_rsp_cnt [3];

  // Item decode.
  logic in_acc, is_push, push_live, do_err, do_store, push_emit, flush_emit, start_med;
  logic clear_pos;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = hrm_pkg::reg_e'(paddr[3:2]);

  always_comb begin
    cfg_hit  = 1'b0;
    radius_d = radius_q;
    width_d  = width_q;
    height_d = height_q;
    prdata   = '0;
    unique case (cfg_idx)
      hrm_pkg::REG_RADIUS: begin
        prdata = hrm_pkg::PDATA_W'(radius_q);
        if (cfg_wr) begin
          radius_d = pwdata[hrm_pkg::RADIUS_W-1:0];
          cfg_hit  = 1'b1;
        end
      end
      hrm_pkg::REG_WIDTH: begin
        prdata = hrm_pkg::PDATA_W'(width_q);
        if (cfg_wr) begin
          width_d = pwdata[hrm_pkg::WIDTH_W-1:0];
          cfg_hit = 1'b1;
        end
      end
      hrm_pkg::REG_HEIGHT: begin
        prdata = hrm_pkg::PDATA_W'(height_q);
        if (cfg_wr) begin
          height_d = pwdata[HW-1:0];
          cfg_hit  = 1'b1;
        end
      end
      default: prdata = '0;
    endcase
  end

  always_comb begin
    r_eff = (32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > hrm_pkg::MAX_HEIGHT) begin
      h_eff = HW'(hrm_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    err    = (32'(r_eff) >= 32'(w_eff)) || (32'(r_eff) >= 32'(h_eff));
    m_last = SW'(2 * 32'(r_eff) + 1);
    two_r  = RCW'(2 * 32'(r_eff));
    win_n  = (2 * RW + 2)'({r_eff, 1'b1}) * (2 * RW + 2)'({r_eff, 1'b1});
    target = CW'(win_n >> 1);
    hm1_s  = $signed(SRW'(h_eff)) - SRW'(1);
    wm1_s  = $signed(JW'(w_eff)) - JW'(1);
  end

  always_comb begin
    in_col_last = (32'(in_col_q) + 1) >= 32'(w_eff);
    in_col_nx   = in_col_last ? '0 : in_col_q + 1'b1;
    in_row_nx   = in_col_last ? in_row_q + 1'b1 : in_row_q;
    in_slot_nx  = in_slot_q;
    if (in_col_last) begin
      in_slot_nx = (in_slot_q == m_last) ? '0 : in_slot_q + 1'b1;
    end
    out_col_last = (32'(out_col_q) + 1) >= 32'(w_eff);
    out_col_nx   = out_col_last ? '0 : out_col_q + 1'b1;
    out_row_nx   = out_col_last ? out_row_q + 1'b1 : out_row_q;
    out_slot_nx  = out_slot_q;
    if (out_col_last) begin
      out_slot_nx = (out_slot_q == m_last) ? '0 : out_slot_q + 1'b1;
    end
  end

  assign in_i.ready = (st_q == hrm_pkg::ST_IDLE);

  always_comb begin
    in_acc     = in_i.valid && in_i.ready;
    is_push    = (in_i.op == hrm_pkg::OP_PUSH);
    push_live  = is_push && (in_row_q < h_eff);
    do_err     = in_acc && push_live && err;
    do_store   = in_acc && push_live && !err;
    push_emit  = do_store && (32'(in_row_q) >= 32'(r_eff) + 1);
    flush_emit = in_acc && !is_push && !err && (in_row_q >= h_eff) && (out_row_q < h_eff);
    start_med  = push_emit || flush_emit;
  end

  // Row slot steps, and the column cursor reflected at the left and right edges of the frame.
  always_comb begin
    slot_up = (slot_q == m_last) ? '0 : slot_q + 1'b1;
    slot_dn = (slot_q == '0) ? m_last : slot_q - 1'b1;
    if (jp_q < 0) begin
      ac_s = -jp_q;
    end else if (jp_q > wm1_s) begin
      ac_s = (wm1_s <<< 1) - jp_q;
    end else begin
      ac_s = jp_q;
    end
    ac       = CAW'(ac_s);
    jp_start = $signed(JW'(ocol_q)) - $signed(JW'(r_eff));
  end

  assign out_load = !out_valid_q || out_o.ready;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      hrm_pkg::ST_CLEAR: if (walk_q[hrm_pkg::BIN_AW]) st_d = hrm_pkg::ST_IDLE;
      hrm_pkg::ST_IDLE: begin
        if (start_med) begin
          st_d = hrm_pkg::ST_PREP;
        end else if (do_err) begin
          st_d = hrm_pkg::ST_EMIT;
        end
      end
      hrm_pkg::ST_PREP: if (prep_q == '0) st_d = hrm_pkg::ST_SCAN;
      hrm_pkg::ST_SCAN: if (rcnt_q == two_r && ccnt_q == two_r) st_d = hrm_pkg::ST_DRAIN;
      hrm_pkg::ST_DRAIN: st_d = hrm_pkg::ST_WALK;
      hrm_pkg::ST_WALK: if (walk_q[hrm_pkg::BIN_AW]) st_d = hrm_pkg::ST_EMIT;
      hrm_pkg::ST_EMIT: if (out_load) st_d = hrm_pkg::ST_IDLE;
      default: st_d = hrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_slot_d  = in_slot_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_slot_d = out_slot_q;
    ip_d       = ip_q;
    slot_d     = slot_q;
    ocol_d     = ocol_q;
    jp_d       = jp_q;
    rcnt_d     = rcnt_q;
    ccnt_d     = ccnt_q;
    prep_d     = prep_q;
    walk_d     = walk_q;
    res_row_end_d = res_row_end_q;
    res_fe_d   = res_fe_q;
    res_err_d  = res_err_q;
    st_re      = 1'b0;
    clear_pos  = cfg_hit;
    for (int ch = 0; ch < 3; ch++) begin
      below_d[ch] = below_q[ch];
      found_d[ch] = found_q[ch];
      med_d[ch]   = med_q[ch];
      sum[ch]     = (CW + 1)'(below_q[ch]) + (CW + 1)'(bin_rsp_cnt[ch]);
      bin_req[ch].valid = st_vld_q;
      bin_req[ch].inc   = 1'b1;
      bin_req[ch].addr  = st_rdata[8*ch +: 8];
    end

    unique case (st_q)
      hrm_pkg::ST_CLEAR: begin
        if (!walk_q[hrm_pkg::BIN_AW]) begin
          for (int ch = 0; ch < 3; ch++) begin
            bin_req[ch].valid = 1'b1;
            bin_req[ch].inc   = 1'b0;
            bin_req[ch].addr  = walk_q[hrm_pkg::BIN_AW-1:0];
          end
          walk_d = walk_q + 1'b1;
        end
      end
      hrm_pkg::ST_IDLE: begin
        if (do_err) begin
          res_row_end_d = (32'(in_col_q) + 1) == 32'(w_eff);
          res_fe_d  = res_row_end_d && ((32'(in_row_q) + 1) == 32'(h_eff));
          res_err_d = 1'b1;
          in_col_d  = in_col_nx;
          in_row_d  = in_row_nx;
          in_slot_d = in_slot_nx;
          if (res_fe_d) clear_pos = 1'b1;
        end
        if (do_store) begin
          in_col_d  = in_col_nx;
          in_row_d  = in_row_nx;
          in_slot_d = in_slot_nx;
        end
        if (start_med) begin
          ip_d   = $signed(SRW'(out_row_q));
          slot_d = out_slot_q;
          ocol_d = out_col_q;
          jp_d   = $signed(JW'(out_col_q)) - $signed(JW'(r_eff));
          rcnt_d = '0;
          ccnt_d = '0;
          prep_d = r_eff;
          res_row_end_d = (32'(out_col_q) + 1) == 32'(w_eff);
          res_fe_d   = flush_emit && (out_row_nx >= h_eff);
          res_err_d  = 1'b0;
          out_col_d  = out_col_nx;
          out_row_d  = out_row_nx;
          out_slot_d = out_slot_nx;
          if (res_fe_d) clear_pos = 1'b1;
        end
      end
      hrm_pkg::ST_PREP: begin
        if (prep_q != '0) begin
          ip_d   = ip_q - SRW'(1);
          prep_d = prep_q - 1'b1;
          slot_d = ((ip_q - SRW'(1)) < 0 || (ip_q - SRW'(1)) >= hm1_s) ? slot_up : slot_dn;
        end
      end
      hrm_pkg::ST_SCAN: begin
        st_re = 1'b1;
        if (ccnt_q == two_r) begin
          ccnt_d = '0;
          jp_d   = jp_start;
          rcnt_d = rcnt_q + 1'b1;
          ip_d   = ip_q + SRW'(1);
          slot_d = ((ip_q + SRW'(1)) <= 0 || (ip_q + SRW'(1)) > hm1_s) ? slot_dn : slot_up;
        end else begin
          ccnt_d = ccnt_q + 1'b1;
          jp_d   = jp_q + JW'(1);
        end
      end
      hrm_pkg::ST_DRAIN: begin
        walk_d = '0;
        for (int ch = 0; ch < 3; ch++) begin
          below_d[ch] = '0;
          found_d[ch] = 1'b0;
          med_d[ch]   = 8'hFF;
        end
      end
      hrm_pkg::ST_WALK: begin
        if (!walk_q[hrm_pkg::BIN_AW]) begin
          for (int ch = 0; ch < 3; ch++) begin
            bin_req[ch].valid = 1'b1;
            bin_req[ch].inc   = 1'b0;
            bin_req[ch].addr  = walk_q[hrm_pkg::BIN_AW-1:0];
          end
          walk_d = walk_q + 1'b1;
        end
        for (int ch = 0; ch < 3; ch++) begin
          if (bin_rsp_valid[ch] && !found_q[ch]) begin
            if (sum[ch] > (CW + 1)'(target)) begin
              found_d[ch] = 1'b1;
              med_d[ch]   = 8'(walk_q - 1'b1);
            end else begin
              below_d[ch] = CW'(sum[ch]);
            end
          end
        end
      end
      hrm_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase

    if (clear_pos) begin
      in_row_d   = '0;
      in_col_d   = '0;
      in_slot_d  = '0;
      out_row_d  = '0;
      out_col_d  = '0;
      out_slot_d = '0;
    end
  end

  always_comb begin
    st_vld_d      = st_re;
    out_valid_d   = out_valid_q;
    out_row_end_d = out_row_end_q;
    out_fe_d      = out_fe_q;
    out_err_d     = out_err_q;
    for (int ch = 0; ch < 3; ch++) begin
      out_ch_d[ch] = out_ch_q[ch];
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (st_q == hrm_pkg::ST_EMIT && out_load) begin
      out_valid_d   = 1'b1;
      out_row_end_d = res_row_end_q;
      out_fe_d      = res_fe_q;
      out_err_d     = res_err_q;
      for (int ch = 0; ch < 3; ch++) begin
        out_ch_d[ch] = res_err_q ? 8'd0 : med_q[ch];
      end
    end
  end

  assign st_we    = do_store;
  assign st_waddr = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  assign st_raddr = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(ac);

  hrm_row_store #(
    .Depth(Depth),
    .AddrW(AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i({in_i.chan2_in, in_i.chan1_in, in_i.chan0_in}),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  for (genvar g = 0; g < 3; g++) begin : g_hist
    hrm_bin_hist #(
      .CntW(CW)
    ) u_hist (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .req_i      (bin_req[g]),
      .rsp_valid_o(bin_rsp_valid[g]),
      .rsp_cnt_o  (bin_rsp_cnt[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= hrm_pkg::RADIUS_W'(1);
      width_q    <= hrm_pkg::WIDTH_W'(1024);
      height_q   <= HW'(768);
      st_q       <= hrm_pkg::ST_CLEAR;
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      walk_q     <= '0;
      st_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      radius_q   <= radius_d;
      width_q    <= width_d;
      height_q   <= height_d;
      st_q       <= st_d;
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      in_slot_q  <= in_slot_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_slot_q <= out_slot_d;
      walk_q     <= walk_d;
      st_vld_q   <= st_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ip_q          <= ip_d;
    slot_q        <= slot_d;
    ocol_q        <= ocol_d;
    jp_q          <= jp_d;
    rcnt_q        <= rcnt_d;
    ccnt_q        <= ccnt_d;
    prep_q        <= prep_d;
    res_row_end_q <= res_row_end_d;
    res_fe_q      <= res_fe_d;
    res_err_q     <= res_err_d;
    out_row_end_q <= out_row_end_d;
    out_fe_q      <= out_fe_d;
    out_err_q     <= out_err_d;
    for (int ch = 0; ch < 3; ch++) begin
      below_q[ch]  <= below_d[ch];
      found_q[ch]  <= found_d[ch];
      med_q[ch]    <= med_d[ch];
      out_ch_q[ch] <= out_ch_d[ch];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.chan0_out  = out_ch_q[0];
  assign out_o.chan1_out  = out_ch_q[1];
  assign out_o.chan2_out  = out_ch_q[2];
  assign out_o.row_end    = out_row_end_q;
  assign out_o.frame_end  = out_fe_q;
  assign out_o.size_error = out_err_q;

  a_store_port_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_we && st_re)) else $error("row store written and read in one cycle");

  a_out_behind_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q <= in_row_q) else $error("output row ahead of input row");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_slot_q <= m_last) && (out_slot_q <= m_last)) else $error("row slot out of range");

  a_walk_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == hrm_pkg::ST_WALK) |-> !st_vld_q) else $error("bin walk overlaps window scan");

endmodule
